// ----- rtl/era_pkg.sv -----
// Shared types, codes and sizes for the expression register ALU.
// No dependencies; every other file imports this package.
package era_pkg;

    localparam int NUM_REGS    = 64;
    localparam int NUM_TABLES  = 16;
    localparam int TABLE_DEPTH = 64;

    localparam int REG_W = $clog2(NUM_REGS);
    localparam int TBL_W = $clog2(NUM_TABLES);
    localparam int ENT_W = $clog2(TABLE_DEPTH);
    localparam int LEN_W = 7;
    localparam int TS_W  = TBL_W + ENT_W;

    // Divider geometry: Q16.16 dividend shifted up by 16 bits.
    localparam int DIV_W     = 48;
    localparam int DSR_W     = 32;
    localparam int DIV_STEPS = DIV_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic [1:0] OP_WR_REG  = 2'd0;
    localparam logic [1:0] OP_EXEC    = 2'd1;
    localparam logic [1:0] OP_WR_ENT  = 2'd2;
    localparam logic [1:0] OP_WR_DESC = 2'd3;

    localparam logic [3:0] ALU_ADD = 4'd0;
    localparam logic [3:0] ALU_SUB = 4'd1;
    localparam logic [3:0] ALU_MUL = 4'd2;
    localparam logic [3:0] ALU_DIV = 4'd3;
    localparam logic [3:0] ALU_MOD = 4'd4;
    localparam logic [3:0] ALU_TBL = 4'd5;
    localparam logic [3:0] ALU_GT  = 4'd6;
    localparam logic [3:0] ALU_GE  = 4'd7;
    localparam logic [3:0] ALU_LT  = 4'd8;
    localparam logic [3:0] ALU_LE  = 4'd9;
    localparam logic [3:0] ALU_EQ  = 4'd10;
    localparam logic [3:0] ALU_NE  = 4'd11;
    localparam logic [3:0] ALU_AND = 4'd12;
    localparam logic [3:0] ALU_OR  = 4'd13;

    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         alu_op;
        logic [REG_W-1:0]   lhs_reg;
        logic [REG_W-1:0]   rhs_reg;
        logic [REG_W-1:0]   dest_reg;
        logic signed [31:0] value;
        logic [TBL_W-1:0]   table_sel;
        logic [ENT_W-1:0]   entry_index;
        logic [LEN_W-1:0]   table_length;
        logic               clamp_mode;
        logic               snap_mode;
    } era_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [REG_W-1:0]   result_reg;
        logic               div_by_zero;
    } era_out_t;

    typedef enum logic [1:0] {MUL_AB, MUL_POS, MUL_E0, MUL_E1} mul_sel_t;
    typedef enum logic [1:0] {DIV_Q, DIV_MOD, DIV_WRAP} div_sel_t;
    typedef enum logic [3:0] {
        RES_VAL, RES_ALU, RES_MUL, RES_DIV, RES_DZ, RES_MOD, RES_ONE, RES_E0, RES_INTERP
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        logic     tbl_wr;
        logic     desc_wr;
        logic     rd_rhs;
        logic     ld_a;
        logic     ld_b;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     ip_clamp;
        logic     ip_wrap;
        logic     tb_nxt;
        logic     ld_e0;
        logic     ld_e1;
        logic     ld_acc;
        logic     res_ld;
        res_sel_t res_sel;
        logic     wb;
    } era_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] alu_op;
        logic       b_zero;
        logic       short_tbl;
        logic       clamp;
        logic       snap;
        logic       div_done;
        logic       out_free;
    } era_stat_t;

endpackage

// ----- rtl/era_if.sv -----
// Valid/ready channel interfaces for input items and result items.
// Depends on era_pkg for the payload structs.
interface era_in_if import era_pkg::*; ();
    logic    valid;
    logic    ready;
    era_in_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface era_out_if import era_pkg::*; ();
    logic     valid;
    logic     ready;
    era_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/expression_register_alu.sv -----
// Top level of the expression register ALU: controller plus datapath.
// Depends on era_pkg, era_if, era_ctrl, era_dp (and era_div below it).
//
// Three-address ALU over 64 signed Q16.16 registers with 16 lookup tables of
// 64 entries. One beat is worked at a time. Table entry and descriptor writes
// give no result. Modulo and a divide by a nonzero value run through the shared
// one-bit-per-cycle restoring divider (48 steps). A table lookup snaps or
// interpolates; wrap mode reuses the divider for the index reduction. The
// result is held in an output register, so the next beat is accepted while a
// result still waits; the block stalls only when a second result is ready
// before the first is taken. Registers read as zero after reset; table
// entries must be written before a lookup reads them.
module expression_register_alu import era_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    era_in_if.sink    item,
    era_out_if.source result
);

    era_cmd_t  cmd;
    era_stat_t stat;
    logic      in_rdy;

    assign item.ready = in_rdy;

    era_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (in_rdy),
        .stat     (stat),
        .cmd      (cmd)
    );

    era_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_data (item.data),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

// ----- rtl/era_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on era_pkg for widths.
module era_div import era_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient,
    output logic [DSR_W-1:0] remainder
);

    logic [DIV_W-1:0]  quo_reg;
    logic [DSR_W-1:0]  rem_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              done_reg;
    logic [DSR_W:0]    trial;
    logic [DSR_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DCNT_W'(DIV_STEPS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == DCNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/era_dp.sv -----
// Datapath: register file, table store, descriptors, multiplier, result register.
// Depends on era_pkg, era_if and era_div; driven by commands from era_ctrl.
module era_dp import era_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  era_in_t   item_data,
    input  era_cmd_t  cmd,
    output era_stat_t stat,
    era_out_if.source result
);

    era_in_t            it_reg;
    logic signed [31:0] rf_mem [NUM_REGS];
    logic               rf_vld_reg [NUM_REGS];
    logic signed [31:0] rf_q_reg;
    logic               rf_qv_reg;
    logic signed [31:0] tbl_mem [NUM_TABLES*TABLE_DEPTH];
    logic signed [31:0] tbl_q_reg;
    logic [LEN_W-1:0]   len_reg [NUM_TABLES];
    logic               clamp_reg [NUM_TABLES];
    logic               snap_reg [NUM_TABLES];

    logic signed [31:0] a_reg, b_reg, e0_reg, e1_reg, res_reg, res_next;
    logic signed [65:0] prod_reg, acc_reg;
    logic signed [32:0] mul_a, mul_b;
    logic [ENT_W-1:0]   ip_reg;
    logic [15:0]        frac_reg;
    logic               force_snap_reg;
    logic               dz_reg;
    logic               out_vld_reg;
    era_out_t           out_reg;

    logic [LEN_W-1:0]   cur_len, dom, dm1;
    logic [REG_W-1:0]   rf_addr;
    logic [TS_W-1:0]    tb_addr;
    logic [31:0]        abs_a, abs_b;
    logic [15:0]        mod_b;
    logic [DIV_W-1:0]   dvd;
    logic [DSR_W-1:0]   dsr;
    logic               div_done;
    logic [DIV_W-1:0]   quo;
    logic [DSR_W-1:0]   rem;
    logic [37:0]        pos, pos_lim;
    logic               out_free;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v[65:31] == '0 || v[65:31] == '1)
            return v[31:0];
        return v[65] ? S32_MIN : S32_MAX;
    endfunction

    assign cur_len = len_reg[it_reg.table_sel];
    assign dom     = cur_len - 1'b1;
    assign dm1     = cur_len - 7'd2;
    assign abs_a   = a_reg[31] ? 32'(-a_reg) : 32'(a_reg);
    assign abs_b   = b_reg[31] ? 32'(-b_reg) : 32'(b_reg);
    assign mod_b   = (abs_b[31:16] == '0) ? 16'd1 : abs_b[31:16];
    assign out_free = !out_vld_reg || result.ready;

    // Capture the beat and the descriptor writes.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            it_reg <= item_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TABLES; i++)
            begin
                len_reg[i]   <= '0;
                clamp_reg[i] <= 1'b0;
                snap_reg[i]  <= 1'b0;
            end
        end
        else if (cmd.desc_wr)
        begin
            len_reg[it_reg.table_sel]   <= (int'(it_reg.table_length) > TABLE_DEPTH) ?
                                           LEN_W'(TABLE_DEPTH) : it_reg.table_length;
            clamp_reg[it_reg.table_sel] <= it_reg.clamp_mode;
            snap_reg[it_reg.table_sel]  <= it_reg.snap_mode;
        end
    end

    // Register file: one write port, one registered read port.
    assign rf_addr = cmd.rd_rhs ? it_reg.rhs_reg : it_reg.lhs_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wb)
            rf_mem[it_reg.dest_reg] <= res_reg;
        rf_q_reg <= rf_mem[rf_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                rf_vld_reg[i] <= 1'b0;
            rf_qv_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wb)
                rf_vld_reg[it_reg.dest_reg] <= 1'b1;
            rf_qv_reg <= rf_vld_reg[rf_addr];
        end
    end

    // Table store.
    assign tb_addr = {it_reg.table_sel, cmd.tb_nxt ? ENT_W'(ip_reg + 1'b1) : ip_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.tbl_wr && int'(it_reg.entry_index) < TABLE_DEPTH)
            tbl_mem[{it_reg.table_sel, it_reg.entry_index}] <= it_reg.value;
        tbl_q_reg <= tbl_mem[tb_addr];
    end

    // Shared multiplier.
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_AB:
            begin
                mul_a = 33'(a_reg);
                mul_b = 33'(b_reg);
            end
            MUL_POS:
            begin
                mul_a = b_reg[31] ? '0 : 33'(b_reg);
                mul_b = $signed({26'b0, it_reg.clamp_mode ? 7'(0) : 7'(0)}) +
                        $signed({26'b0, clamp_reg[it_reg.table_sel] ? dm1 : dom});
            end
            MUL_E0:
            begin
                mul_a = 33'(e0_reg);
                mul_b = $signed({16'b0, 17'h1_0000 - {1'b0, frac_reg}});
            end
            MUL_E1:
            begin
                mul_a = 33'(e1_reg);
                mul_b = $signed({17'b0, frac_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.ld_acc)
            acc_reg <= prod_reg;
        if (cmd.ld_a)
            a_reg <= rf_qv_reg ? rf_q_reg : '0;
        if (cmd.ld_b)
            b_reg <= rf_qv_reg ? rf_q_reg : '0;
        if (cmd.ld_e0)
            e0_reg <= tbl_q_reg;
        if (cmd.ld_e1)
            e1_reg <= tbl_q_reg;
    end

    // Divider operands.
    always_comb
    begin
        case (cmd.div_sel)
            DIV_Q:
            begin
                dvd = {abs_a, 16'b0};
                dsr = abs_b;
            end
            DIV_MOD:
            begin
                dvd = DIV_W'(abs_a[31:16]);
                dsr = DSR_W'(mod_b);
            end
            DIV_WRAP:
            begin
                dvd = prod_reg[DIV_W+15:16];
                dsr = DSR_W'(dom);
            end
            default:
            begin
                dvd = '0;
                dsr = '0;
            end
        endcase
    end

    era_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dvd),
        .divisor   (dsr),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // Lookup position: clamp-mode endpoints take entry 0 or entry length-2 as is.
    assign pos     = prod_reg[37:0];
    assign pos_lim = 38'(dm1) << 16;

    always_ff @(posedge clk)
    begin
        if (cmd.ip_clamp)
        begin
            frac_reg <= pos[15:0];
            if (pos >= pos_lim)
            begin
                ip_reg         <= dm1[ENT_W-1:0];
                force_snap_reg <= 1'b1;
            end
            else if (pos == '0)
            begin
                ip_reg         <= '0;
                force_snap_reg <= 1'b1;
            end
            else
            begin
                ip_reg         <= pos[ENT_W+15:16];
                force_snap_reg <= 1'b0;
            end
        end
        else if (cmd.ip_wrap)
        begin
            ip_reg         <= rem[ENT_W-1:0];
            frac_reg       <= pos[15:0];
            force_snap_reg <= 1'b0;
        end
    end

    // Result selection.
    always_comb
    begin
        res_next = '0;
        case (cmd.res_sel)
            RES_VAL: res_next = it_reg.value;
            RES_ALU:
            begin
                case (it_reg.alu_op)
                    ALU_ADD: res_next = sat32(66'(a_reg) + 66'(b_reg));
                    ALU_SUB: res_next = sat32(66'(a_reg) - 66'(b_reg));
                    ALU_GT:  res_next = (a_reg >  b_reg) ? Q_ONE : '0;
                    ALU_GE:  res_next = (a_reg >= b_reg) ? Q_ONE : '0;
                    ALU_LT:  res_next = (a_reg <  b_reg) ? Q_ONE : '0;
                    ALU_LE:  res_next = (a_reg <= b_reg) ? Q_ONE : '0;
                    ALU_EQ:  res_next = (a_reg == b_reg) ? Q_ONE : '0;
                    ALU_NE:  res_next = (a_reg != b_reg) ? Q_ONE : '0;
                    ALU_AND: res_next = (a_reg != '0 && b_reg != '0) ? Q_ONE : '0;
                    ALU_OR:  res_next = (a_reg != '0 || b_reg != '0) ? Q_ONE : '0;
                    default: res_next = '0;
                endcase
            end
            RES_MUL: res_next = sat32(prod_reg >>> 16);
            RES_DIV:
            begin
                if (a_reg[31] ^ b_reg[31])
                    res_next = sat32(-$signed({18'b0, quo}));
                else
                    res_next = sat32($signed({18'b0, quo}));
            end
            RES_DZ:
            begin
                if (a_reg > 0)
                    res_next = S32_MAX;
                else if (a_reg < 0)
                    res_next = S32_MIN;
                else
                    res_next = '0;
            end
            RES_MOD: res_next = a_reg[31] ? -$signed({rem[15:0], 16'b0}) :
                                            $signed({rem[15:0], 16'b0});
            RES_ONE: res_next = Q_ONE;
            RES_E0:  res_next = e0_reg;
            RES_INTERP: res_next = sat32((acc_reg + prod_reg) >>> 16);
            default: res_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_ld)
        begin
            res_reg <= res_next;
            dz_reg  <= (cmd.res_sel == RES_DZ);
        end
        if (cmd.wb && out_free)
        begin
            out_reg.result_value <= res_reg;
            out_reg.result_reg   <= it_reg.dest_reg;
            out_reg.div_by_zero  <= dz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cmd.wb && out_free)
            out_vld_reg <= 1'b1;
        else if (result.ready)
            out_vld_reg <= 1'b0;
    end

    assign result.valid = out_vld_reg;
    assign result.data  = out_reg;

    assign stat.op        = it_reg.op;
    assign stat.alu_op    = it_reg.alu_op;
    assign stat.b_zero    = (b_reg == '0);
    assign stat.short_tbl = (cur_len <= 7'd2);
    assign stat.clamp     = clamp_reg[it_reg.table_sel];
    assign stat.snap      = snap_reg[it_reg.table_sel] || force_snap_reg;
    assign stat.div_done  = div_done;
    assign stat.out_free  = out_free;

endmodule

// ----- rtl/era_ctrl.sv -----
// Controller state machine: sequences each item as a short micro-program.
// Depends on era_pkg for command, status and opcode definitions.
module era_ctrl import era_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  era_stat_t stat,
    output era_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_RDA  = 4'd2;
    localparam logic [3:0] S_RDB  = 4'd3;
    localparam logic [3:0] S_EXE  = 4'd4;
    localparam logic [3:0] S_MULF = 4'd5;
    localparam logic [3:0] S_DIVW = 4'd6;
    localparam logic [3:0] S_TPOS = 4'd7;
    localparam logic [3:0] S_TRD0 = 4'd8;
    localparam logic [3:0] S_TRD1 = 4'd9;
    localparam logic [3:0] S_TRD2 = 4'd10;
    localparam logic [3:0] S_TM0  = 4'd11;
    localparam logic [3:0] S_TM1  = 4'd12;
    localparam logic [3:0] S_WB   = 4'd13;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                case (stat.op)
                    OP_WR_ENT:
                    begin
                        cmd.tbl_wr = 1'b1;
                        state_next = S_IDLE;
                    end
                    OP_WR_DESC:
                    begin
                        cmd.desc_wr = 1'b1;
                        state_next  = S_IDLE;
                    end
                    OP_WR_REG:
                    begin
                        cmd.res_ld  = 1'b1;
                        cmd.res_sel = RES_VAL;
                        state_next  = S_WB;
                    end
                    default:
                    begin
                        // Unused ALU operation codes drop the beat.
                        state_next = (stat.alu_op > ALU_OR) ? S_IDLE : S_RDA;
                    end
                endcase
            end
            S_RDA:
            begin
                cmd.ld_a   = 1'b1;
                cmd.rd_rhs = 1'b1;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.ld_b   = 1'b1;
                state_next = S_EXE;
            end
            S_EXE:
            begin
                case (stat.alu_op)
                    ALU_MUL:
                    begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_AB;
                        state_next  = S_MULF;
                    end
                    ALU_DIV:
                    begin
                        if (stat.b_zero)
                        begin
                            cmd.res_ld  = 1'b1;
                            cmd.res_sel = RES_DZ;
                            state_next  = S_WB;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            cmd.div_sel   = DIV_Q;
                            state_next    = S_DIVW;
                        end
                    end
                    ALU_MOD:
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_MOD;
                        state_next    = S_DIVW;
                    end
                    ALU_TBL:
                    begin
                        if (stat.short_tbl)
                        begin
                            cmd.res_ld  = 1'b1;
                            cmd.res_sel = RES_ONE;
                            state_next  = S_WB;
                        end
                        else
                        begin
                            cmd.mul_en  = 1'b1;
                            cmd.mul_sel = MUL_POS;
                            state_next  = S_TPOS;
                        end
                    end
                    default:
                    begin
                        cmd.res_ld  = 1'b1;
                        cmd.res_sel = RES_ALU;
                        state_next  = S_WB;
                    end
                endcase
            end
            S_MULF:
            begin
                cmd.res_ld  = 1'b1;
                cmd.res_sel = RES_MUL;
                state_next  = S_WB;
            end
            S_DIVW:
            begin
                cmd.div_sel = (stat.alu_op == ALU_TBL) ? DIV_WRAP : DIV_Q;
                if (stat.div_done)
                begin
                    if (stat.alu_op == ALU_TBL)
                    begin
                        cmd.ip_wrap = 1'b1;
                        state_next  = S_TRD0;
                    end
                    else
                    begin
                        cmd.res_ld  = 1'b1;
                        cmd.res_sel = (stat.alu_op == ALU_DIV) ? RES_DIV : RES_MOD;
                        state_next  = S_WB;
                    end
                end
            end
            S_TPOS:
            begin
                if (stat.clamp)
                begin
                    cmd.ip_clamp = 1'b1;
                    state_next   = S_TRD0;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_WRAP;
                    state_next    = S_DIVW;
                end
            end
            S_TRD0:
            begin
                state_next = S_TRD1;
            end
            S_TRD1:
            begin
                cmd.ld_e0  = 1'b1;
                cmd.tb_nxt = 1'b1;
                state_next = S_TRD2;
            end
            S_TRD2:
            begin
                if (stat.snap)
                begin
                    cmd.res_ld  = 1'b1;
                    cmd.res_sel = RES_E0;
                    state_next  = S_WB;
                end
                else
                begin
                    cmd.ld_e1   = 1'b1;
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_E0;
                    state_next  = S_TM0;
                end
            end
            S_TM0:
            begin
                cmd.ld_acc  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_E1;
                state_next  = S_TM1;
            end
            S_TM1:
            begin
                cmd.res_ld  = 1'b1;
                cmd.res_sel = RES_INTERP;
                state_next  = S_WB;
            end
            S_WB:
            begin
                // Hold until the output register can take the beat.
                if (stat.out_free)
                begin
                    cmd.wb     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
